### rtl/ctsc_pkg.sv
package ctsc_pkg;

    localparam int NEST_LIMIT = 255;
    // Depth counters are eight bits wide, so the usable limit never exceeds 255.
    localparam int DEPTH_CAP_INT = (NEST_LIMIT < 255) ? NEST_LIMIT : 255;
    localparam logic [7:0] DEPTH_CAP = 8'(DEPTH_CAP_INT);

    typedef enum logic [3:0] {
        OP_UNKNOWN     = 4'd0,
        OP_TABLE_OPEN  = 4'd1,
        OP_TABLE_CLOSE = 4'd2,
        OP_ARRAY_OPEN  = 4'd3,
        OP_ARRAY_CLOSE = 4'd4,
        OP_BRACE_OPEN  = 4'd5,
        OP_BRACE_CLOSE = 4'd6,
        OP_KEY         = 4'd7,
        OP_EQUALS      = 4'd8,
        OP_VALUE       = 4'd9,
        OP_NEWLINE     = 4'd10,
        OP_COMMA       = 4'd11,
        OP_DOT         = 4'd12,
        OP_END         = 4'd13
    } t_opcode;

    typedef enum logic [1:0] {
        ST_FINE     = 2'd0,
        ST_ERROR    = 2'd1,
        ST_END_PASS = 2'd2,
        ST_END_FAIL = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode     opcode;
        logic [19:0] token_line;
        logic [15:0] token_column;
    } t_token;

    typedef struct packed {
        t_status     status;
        logic [19:0] error_line;
        logic [15:0] error_column;
    } t_result;

    typedef struct packed {
        logic [7:0]  array_depth;
        logic [7:0]  brace_depth;
        logic        expecting_value;
        logic        in_table_header;
        logic        last_was_value;
        logic        key_pending;
        logic [19:0] pending_key_line;
        logic [15:0] pending_key_column;
        logic        error_latched;
        logic [19:0] saved_error_line;
        logic [15:0] saved_error_column;
    } t_state;

endpackage

### rtl/config_token_syntax_checker_top.sv
// Token syntax checker for a key/value configuration stream.
// The input channel carries one classified token per beat (kind, line and
// column); an end token closes the stream. The output channel carries one
// result beat per input beat: a running status, or the final verdict for an
// end token, together with the location of the first offending token.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. An accepted beat is written into an input register, checked
// against the stream state by a single combinational step, and its result is
// written into the output register once that register is empty or is being
// emptied; the receiver takes the result from there.
// Throughput is one token per cycle unless the receiver stalls: the state
// update is a single short step and the input and output registers work as
// a two-entry pipeline.
// When the receiver stalls, the result stays in the output register, the
// waiting token stays in the input register, and input stall is raised only
// once both registers are occupied.
// A synchronous, active-low reset empties both registers and returns the
// stream state to its start: no depth, no open header, no pending key and no
// latched error. An end token does the same to the stream state after
// reporting, so the next token opens a new stream.
module config_token_syntax_checker_top
    import ctsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_token  i_in_tok,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_res
);

    logic    r_in_valid;
    t_token  r_in_tok;
    logic    r_out_valid;
    t_result r_out_res;
    t_state  r_state;

    t_state  n_state;
    t_result n_res;
    logic    advance;
    logic    in_take;

    // The token in the input register moves on when the output register is
    // empty or is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    ctsc_step u_step (
        .i_state (r_state),
        .i_tok   (r_in_tok),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tok <= i_in_tok;
        end
        if (advance) begin
            r_out_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

### rtl/ctsc_step.sv
module ctsc_step
    import ctsc_pkg::*;
(
    input  t_state  i_state,
    input  t_token  i_tok,
    output t_state  o_state,
    output t_result o_res
);

    t_state s;
    logic   hit;

    always_comb begin
        s     = i_state;
        hit   = 1'b0;
        o_res = '0;

        if (i_tok.opcode == OP_END) begin
            if (i_state.error_latched) begin
                o_res.status       = ST_END_FAIL;
                o_res.error_line   = i_state.saved_error_line;
                o_res.error_column = i_state.saved_error_column;
            end else if (i_state.array_depth != 8'd0 || i_state.brace_depth != 8'd0 ||
                         i_state.expecting_value || i_state.in_table_header) begin
                o_res.status = ST_END_FAIL;
            end else begin
                o_res.status = ST_END_PASS;
            end
            s = '0;
        end else begin
            if (!i_state.error_latched) begin
                // A key must be followed directly by an equals sign.
                if (i_state.key_pending) begin
                    s.key_pending = 1'b0;
                    if (i_tok.opcode != OP_EQUALS) begin
                        s.error_latched      = 1'b1;
                        s.saved_error_line   = i_state.pending_key_line;
                        s.saved_error_column = i_state.pending_key_column;
                    end
                end
                if (!s.error_latched) begin
                    case (i_tok.opcode)
                        OP_TABLE_OPEN: begin
                            if (i_state.expecting_value) hit = 1'b1;
                            else s.in_table_header = 1'b1;
                        end
                        OP_TABLE_CLOSE: begin
                            if (!i_state.in_table_header) hit = 1'b1;
                            else s.in_table_header = 1'b0;
                        end
                        OP_ARRAY_OPEN: begin
                            if (i_state.in_table_header || i_state.array_depth >= DEPTH_CAP) begin
                                hit = 1'b1;
                            end else begin
                                s.array_depth    = i_state.array_depth + 8'd1;
                                s.last_was_value = 1'b0;
                            end
                        end
                        OP_ARRAY_CLOSE: begin
                            if (i_state.in_table_header || i_state.array_depth == 8'd0) begin
                                hit = 1'b1;
                            end else begin
                                s.array_depth    = i_state.array_depth - 8'd1;
                                s.last_was_value = 1'b0;
                            end
                        end
                        OP_BRACE_OPEN: begin
                            if (i_state.in_table_header || i_state.brace_depth >= DEPTH_CAP) begin
                                hit = 1'b1;
                            end else begin
                                s.brace_depth = i_state.brace_depth + 8'd1;
                            end
                        end
                        OP_BRACE_CLOSE: begin
                            if (i_state.in_table_header || i_state.brace_depth == 8'd0) begin
                                hit = 1'b1;
                            end else begin
                                s.brace_depth = i_state.brace_depth - 8'd1;
                            end
                        end
                        OP_KEY: begin
                            if (!i_state.in_table_header) begin
                                s.key_pending        = 1'b1;
                                s.pending_key_line   = i_tok.token_line;
                                s.pending_key_column = i_tok.token_column;
                                s.expecting_value    = 1'b1;
                            end
                        end
                        OP_EQUALS: begin
                            hit = i_state.in_table_header || !i_state.expecting_value;
                        end
                        OP_VALUE: begin
                            if (i_state.in_table_header) begin
                                hit = 1'b1;
                            end else if (!i_state.expecting_value &&
                                         i_state.array_depth == 8'd0 &&
                                         i_state.brace_depth == 8'd0) begin
                                hit = 1'b1;
                            end else begin
                                s.expecting_value = 1'b0;
                                if (i_state.array_depth != 8'd0) begin
                                    if (i_state.last_was_value) hit = 1'b1;
                                    else s.last_was_value = 1'b1;
                                end
                            end
                        end
                        OP_NEWLINE: begin
                            s.expecting_value = 1'b0;
                        end
                        OP_COMMA: begin
                            if (i_state.in_table_header) begin
                                hit = 1'b1;
                            end else begin
                                s.expecting_value = 1'b0;
                                s.last_was_value  = 1'b0;
                            end
                        end
                        OP_DOT: begin
                            hit = 1'b0;
                        end
                        default: begin
                            hit = 1'b1;
                        end
                    endcase
                    if (hit) begin
                        s.error_latched      = 1'b1;
                        s.saved_error_line   = i_tok.token_line;
                        s.saved_error_column = i_tok.token_column;
                    end
                end
            end
            if (s.error_latched) begin
                o_res.status       = ST_ERROR;
                o_res.error_line   = s.saved_error_line;
                o_res.error_column = s.saved_error_column;
            end else begin
                o_res.status = ST_FINE;
            end
        end
        o_state = s;
    end

endmodule

### rtl/ctsc_checker.sv
module ctsc_checker
    import ctsc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input t_token  i_in_tok,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_result o_out_res
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result beat changed");

    // Input stall only arises when the output side is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // Fine and passed results carry no location.
    a_clean_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_res.status == ST_FINE || o_out_res.status == ST_END_PASS)
        |-> o_out_res.error_line == 20'd0 && o_out_res.error_column == 16'd0)
        else $error("location reported without an error");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind config_token_syntax_checker_top ctsc_checker u_ctsc_checker (.*);

### verif/ctsc_verdict_checker.sv
module ctsc_verdict_checker
    import ctsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_token  i_in_tok,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_result i_out_res,
    output int      o_fail_count,
    output int      o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // Stream state as the checker sees it.
    logic [7:0]  arr_lvl;
    logic [7:0]  brc_lvl;
    logic        want_value;
    logic        header_open;
    logic        prev_elem_value;
    logic        key_waiting;
    logic [19:0] key_line;
    logic [15:0] key_col;
    logic        err_seen;
    logic [19:0] err_line;
    logic [15:0] err_col;

    t_result expected_verdicts[$];
    int      fails = 0;

    function automatic void clear_stream();
        arr_lvl         = '0;
        brc_lvl         = '0;
        want_value      = 1'b0;
        header_open     = 1'b0;
        prev_elem_value = 1'b0;
        key_waiting     = 1'b0;
        key_line        = '0;
        key_col         = '0;
        err_seen        = 1'b0;
        err_line        = '0;
        err_col         = '0;
    endfunction

    function automatic void latch_error(logic [19:0] line_no, logic [15:0] col_no);
        err_seen = 1'b1;
        err_line = line_no;
        err_col  = col_no;
    endfunction

    // Advances the stream state by one token and returns the verdict beat it causes.
    function automatic t_result next_verdict(t_token tok);
        t_result verdict;
        logic    bad;
        verdict = '0;
        bad     = 1'b0;
        if (tok.opcode == OP_END) begin
            if (err_seen) begin
                verdict.status       = ST_END_FAIL;
                verdict.error_line   = err_line;
                verdict.error_column = err_col;
            end else if (arr_lvl != 0 || brc_lvl != 0 || want_value || header_open) begin
                verdict.status = ST_END_FAIL;
            end else begin
                verdict.status = ST_END_PASS;
            end
            clear_stream();
        end else begin
            if (!err_seen && key_waiting) begin
                key_waiting = 1'b0;
                if (tok.opcode != OP_EQUALS) latch_error(key_line, key_col);
            end
            if (!err_seen) begin
                case (tok.opcode)
                    OP_TABLE_OPEN: if (want_value) bad = 1'b1; else header_open = 1'b1;
                    OP_TABLE_CLOSE: if (!header_open) bad = 1'b1; else header_open = 1'b0;
                    OP_ARRAY_OPEN: begin
                        if (header_open || arr_lvl >= DEPTH_CAP) bad = 1'b1;
                        else begin
                            arr_lvl++;
                            prev_elem_value = 1'b0;
                        end
                    end
                    OP_ARRAY_CLOSE: begin
                        if (header_open || arr_lvl == 0) bad = 1'b1;
                        else begin
                            arr_lvl--;
                            prev_elem_value = 1'b0;
                        end
                    end
                    OP_BRACE_OPEN: begin
                        if (header_open || brc_lvl >= DEPTH_CAP) bad = 1'b1;
                        else brc_lvl++;
                    end
                    OP_BRACE_CLOSE: begin
                        if (header_open || brc_lvl == 0) bad = 1'b1;
                        else brc_lvl--;
                    end
                    OP_KEY: begin
                        if (!header_open) begin
                            key_waiting = 1'b1;
                            key_line    = tok.token_line;
                            key_col     = tok.token_column;
                            want_value  = 1'b1;
                        end
                    end
                    OP_EQUALS: bad = header_open || !want_value;
                    OP_VALUE: begin
                        if (header_open || (!want_value && arr_lvl == 0 && brc_lvl == 0)) begin
                            bad = 1'b1;
                        end else begin
                            want_value = 1'b0;
                            if (arr_lvl != 0) begin
                                if (prev_elem_value) bad = 1'b1;
                                else prev_elem_value = 1'b1;
                            end
                        end
                    end
                    OP_NEWLINE: want_value = 1'b0;
                    OP_COMMA: begin
                        if (header_open) bad = 1'b1;
                        else begin
                            want_value      = 1'b0;
                            prev_elem_value = 1'b0;
                        end
                    end
                    OP_DOT: ;
                    default: bad = 1'b1;
                endcase
                if (bad) latch_error(tok.token_line, tok.token_column);
            end
            if (err_seen) begin
                verdict.status       = ST_ERROR;
                verdict.error_line   = err_line;
                verdict.error_column = err_col;
            end else begin
                verdict.status = ST_FINE;
            end
        end
        return verdict;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            clear_stream();
            expected_verdicts.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predicted = next_verdict(i_in_tok);
                expected_verdicts.insert(expected_verdicts.size(), predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result beat with nothing expected: status %0d line %0d column %0d",
                             $time, i_out_res.status, i_out_res.error_line,
                             i_out_res.error_column);
                    fails++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_out_res.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_out_res.status);
                        fails++;
                    end
                    if (i_out_res.error_line !== want.error_line) begin
                        $display("%0t: error_line expected %0d, got %0d",
                                 $time, want.error_line, i_out_res.error_line);
                        fails++;
                    end
                    if (i_out_res.error_column !== want.error_column) begin
                        $display("%0t: error_column expected %0d, got %0d",
                                 $time, want.error_column, i_out_res.error_column);
                        fails++;
                    end
                end
            end
        end
        // Published with nonblocking assignments so that readers at this edge see the old values.
        o_fail_count <= fails;
        o_pending    <= expected_verdicts.size();
    end

endmodule

### verif/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ctsc_pkg::*;

    // The random part stops once this many token beats have gone in; the last
    // QUIET_TOKENS of them run with neither side idling.
    localparam int RANDOM_TOKENS = 550;
    localparam int QUIET_TOKENS  = 60;
    // Far beyond the slowest legal run: every beat waiting out the longest
    // sender gap and the longest receiver stall, plus the two-stage pipeline.
    localparam int CYCLE_LIMIT   = 500000;
    // Once every result is in, the drain catches any stray beat that should not be there.
    localparam int DRAIN_CYCLES  = 8;
    // Opcodes above the end token are not defined and must count as errors.
    localparam logic [3:0] FIRST_UNDEFINED_OP = OP_END + 4'd1;
    localparam logic [3:0] LAST_UNDEFINED_OP  = OP_END + 4'd2;

    logic    clk;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    t_token  in_tok    = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_result out_res;

    int      fail_count;
    int      pending_count;

    // Tokens of the stream being assembled, sent as a whole by send_run.
    t_token  token_run[$];
    int      tokens_sent = 0;
    int      streams_sent = 0;
    int      random_start;
    int      gap_pct = 0;
    bit      quiet_tail = 1'b0;

    config_token_syntax_checker_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_tok    (in_tok),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res)
    );

    ctsc_verdict_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_tok     (in_tok),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_res    (out_res),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hung handshake ends the run here rather than leaving it to spin.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, pending_count);
        $display("config_token_syntax_checker_top test failed");
        $finish;
    end

    // The receiver stalls in bursts, separated by calm stretches of varying
    // length, some of them long. Once the quiet tail begins it starts no new
    // stall.
    initial begin
        forever begin
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 40))
                @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 2) != 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Location fields lean on their extremes now and then so that every bit
    // sees both values, and zero and all ones turn up as real locations.
    function automatic logic [19:0] pick_location_bits();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic void emit_at(logic [3:0] op, logic [19:0] line_no, logic [15:0] col_no);
        t_token tok;
        tok.opcode       = t_opcode'(op);
        tok.token_line   = line_no;
        tok.token_column = col_no;
        token_run.insert(token_run.size(), tok);
    endfunction

    function automatic void emit(logic [3:0] op);
        emit_at(op, pick_location_bits(), 16'(pick_location_bits()));
    endfunction

    // A value on the right of an equals sign: mostly a plain value, sometimes
    // an array or an inline table, nested up to three levels deep.
    function automatic void add_value(int nest);
        int n;
        case (nest < 3 ? $urandom_range(0, 5) : 0)
            1: begin
                emit(OP_ARRAY_OPEN);
                n = $urandom_range(0, 3);
                for (int k = 0; k < n; k++) begin
                    if (k != 0) emit(OP_COMMA);
                    add_value(nest + 1);
                end
                emit(OP_ARRAY_CLOSE);
            end
            2: begin
                emit(OP_BRACE_OPEN);
                n = $urandom_range(0, 2);
                for (int k = 0; k < n; k++) begin
                    if (k != 0) emit(OP_COMMA);
                    emit(OP_KEY);
                    emit(OP_EQUALS);
                    add_value(nest + 1);
                end
                emit(OP_BRACE_CLOSE);
            end
            default: emit(OP_VALUE);
        endcase
    endfunction

    // Sends the assembled stream one beat at a time. Before a beat the
    // sender may drop valid, with a chance set per stream, so the gaps land
    // on every stage of the pipeline. Valid and payload change only once the
    // previous beat has been taken.
    task automatic send_run();
        foreach (token_run[i]) begin
            if (tokens_sent - random_start >= RANDOM_TOKENS - QUIET_TOKENS) quiet_tail = 1'b1;
            if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_tok   <= token_run[i];
            @(posedge clk);
            while (in_stall) @(posedge clk);
            tokens_sent++;
            if (token_run[i].opcode == OP_END) streams_sent++;
        end
        token_run.delete();
    endtask

    initial begin
        int pos;
        random_start = RANDOM_TOKENS;   // keeps the quiet tail off until the random part starts
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed streams, each closed by an end token.
        gap_pct = 20;
        // A clean assignment with the key at the largest line and column.
        emit_at(OP_KEY, '1, '1);
        emit(OP_EQUALS);
        emit(OP_VALUE);
        emit(OP_END);
        // A dotted table header: keys and dots inside a header are ignored.
        emit(OP_TABLE_OPEN);
        emit(OP_KEY);
        emit(OP_DOT);
        emit(OP_TABLE_CLOSE);
        emit(OP_END);
        // A key followed by a newline instead of an equals sign: the error
        // carries the key's location, not the newline's.
        emit_at(OP_KEY, 20'h5A5A5, 16'hA5A5);
        emit(OP_NEWLINE);
        emit(OP_END);
        // A key followed straight by end: no error, but the end fails since
        // a value is still expected.
        emit(OP_KEY);
        emit(OP_END);
        // A brace pair, then an array close at depth zero; the token after
        // the error is ignored and the end reports the saved location.
        emit(OP_BRACE_OPEN);
        emit(OP_BRACE_CLOSE);
        emit_at(OP_ARRAY_CLOSE, '0, '0);
        emit(OP_BRACE_OPEN);
        emit(OP_END);
        // An undefined opcode.
        emit(LAST_UNDEFINED_OP);
        emit(OP_END);
        // An array left open with a comma inside: the end fails on depth.
        emit(OP_ARRAY_OPEN);
        emit(OP_VALUE);
        emit(OP_COMMA);
        emit(OP_END);
        // A value that nothing asked for.
        emit(OP_VALUE);
        emit(OP_END);
        send_run();

        // Nesting to the limit on each kind of bracket; one open past it
        // must be refused.
        gap_pct = 2;
        repeat (DEPTH_CAP) emit(OP_ARRAY_OPEN);
        emit(OP_ARRAY_OPEN);
        emit(OP_END);
        send_run();
        repeat (DEPTH_CAP) emit(OP_BRACE_OPEN);
        emit(OP_BRACE_OPEN);
        emit(OP_END);
        send_run();

        // Random streams. Most are well-formed lines with random content,
        // so the checker gets past its first states; some have one token
        // dropped, added or swapped, and a few are plain noise.
        random_start = tokens_sent;
        while (tokens_sent - random_start < RANDOM_TOKENS) begin
            case ($urandom_range(0, 4))
                0:       gap_pct = 50;
                1:       gap_pct = 15;
                default: gap_pct = 0;
            endcase
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 8)) emit(4'($urandom));
                if ($urandom_range(0, 1) == 0) emit(FIRST_UNDEFINED_OP);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            emit(OP_TABLE_OPEN);
                            emit(OP_KEY);
                            repeat ($urandom_range(0, 2)) begin
                                emit(OP_DOT);
                                emit(OP_KEY);
                            end
                            emit(OP_TABLE_CLOSE);
                        end
                        1: ;    // blank line
                        default: begin
                            emit(OP_KEY);
                            emit(OP_EQUALS);
                            add_value(0);
                        end
                    endcase
                    emit(OP_NEWLINE);
                end
                if ($urandom_range(0, 9) < 3) begin
                    pos = $urandom_range(0, token_run.size() - 1);
                    case ($urandom_range(0, 2))
                        0: token_run.delete(pos);
                        1: begin
                            emit(4'($urandom));
                            token_run.insert(pos, token_run.pop_back());
                        end
                        default: token_run[pos].opcode = t_opcode'(4'($urandom));
                    endcase
                end
            end
            emit(OP_END);
            send_run();
        end
        in_valid <= 1'b0;

        // One edge first so that the last accepted beat is counted as
        // outstanding, then wait for every result and a short drain.
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d token beats in %0d streams: directed cases, nesting to depth %0d",
                 tokens_sent, streams_sent, DEPTH_CAP);
        $display("on arrays and braces, and random lines with damaged tokens and noise.");
        if (fail_count == 0) begin
            $display("config_token_syntax_checker_top test passed");
        end else begin
            $display("config_token_syntax_checker_top test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ctsc_pkg.sv
rtl/ctsc_step.sv
rtl/config_token_syntax_checker_top.sv
rtl/ctsc_checker.sv
verif/ctsc_verdict_checker.sv
verif/tb.sv
